### design/hws_pkg.sv
package hws_pkg;

  // Width of one multiplier digit taken per cycle by the shared multiplier.
  localparam int MulDigit = 16;

  // Quotient bits produced per cycle by the series divider.
  localparam int DivStep = 4;

  // Width of the series divisors (2k)(2k+1), the largest being 600.
  localparam int CoefBits = 10;

  localparam int SeriesTerms = 12;
  localparam int TermIdxBits = 4;

  // New-sample weight of the error leak in Q0.32; the old weight is 2^32 minus this.
  localparam logic [30:0] LeakNew = 31'd1640531527;

  // floor(1.57079634 * 2^w) by exact long division of the decimal fraction.
  function automatic logic [63:0] curve_const(input int w);
    logic [63:0] q;
    logic [27:0] r;
    q = 64'd1;
    r = 28'd57079634;
    for (int i = 0; i < w; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= 28'd100000000) begin
        r = r - 28'd100000000;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // (cw * cw) >> w, the squared curve constant on the same fixed-point grid.
  function automatic logic [63:0] curve_square(input int w);
    logic [127:0] cw;
    logic [127:0] p;
    cw = {64'd0, curve_const(w)};
    p  = cw * cw;
    return 64'(p >> w);
  endfunction

  // Divisor of series term k: (2k)(2k+1).
  function automatic logic [CoefBits-1:0] series_coef(input logic [TermIdxBits-1:0] k);
    logic [CoefBits-1:0] c;
    unique case (k)
      4'd1:    c = 10'd6;
      4'd2:    c = 10'd20;
      4'd3:    c = 10'd42;
      4'd4:    c = 10'd72;
      4'd5:    c = 10'd110;
      4'd6:    c = 10'd156;
      4'd7:    c = 10'd210;
      4'd8:    c = 10'd272;
      4'd9:    c = 10'd342;
      4'd10:   c = 10'd420;
      4'd11:   c = 10'd506;
      4'd12:   c = 10'd600;
      default: c = 10'd1;
    endcase
    return c;
  endfunction

endpackage

### design/hws_mul.sv
// Shared unsigned multiplier: one MulDigit-wide digit of b per cycle,
// shift-right accumulation, full 2*WIDTH-bit product at the end.
module hws_mul import hws_pkg::*; #(
  parameter int WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic                 done_o,
  output logic [2*WIDTH-1:0]   prod_o
);

  localparam int Steps = WIDTH / MulDigit;
  localparam int CntW  = $clog2(Steps + 1);

  logic [WIDTH-1:0]          a_q, a_d;
  logic [WIDTH-1:0]          b_q, b_d;
  logic [2*WIDTH-1:0]        p_q, p_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [WIDTH+MulDigit-1:0] hi_sum;

  assign hi_sum = (WIDTH+MulDigit)'(p_q[2*WIDTH-1:WIDTH]) +
                  (WIDTH+MulDigit)'(a_q) * (WIDTH+MulDigit)'(b_q[MulDigit-1:0]);

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      p_d    = '0;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {hi_sum, p_q[WIDTH-1:MulDigit]};
      b_d   = b_q >> MulDigit;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

### design/hws_div.sv
// Radix-16 restoring divider by a small constant divisor, DivStep quotient
// bits per cycle. The remainder never exceeds the divisor width.
module hws_div import hws_pkg::*; #(
  parameter int WIDTH = 44
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [CoefBits-1:0] divisor_i,
  output logic                done_o,
  output logic [WIDTH-1:0]    quot_o
);

  localparam int Steps = WIDTH / DivStep;
  localparam int CntW  = $clog2(Steps + 1);

  logic [WIDTH-1:0]    quo_q, quo_d;
  logic [CoefBits-1:0] rem_q, rem_d;
  logic [CoefBits-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [WIDTH-1:0]    q_w;
  logic [CoefBits-1:0] r_w;
  logic [CoefBits:0]   trial;

  // DivStep restoring steps on the narrow remainder.
  always_comb begin
    q_w   = quo_q;
    r_w   = rem_q;
    trial = '0;
    for (int i = 0; i < DivStep; i++) begin
      trial = {r_w, q_w[WIDTH-1]};
      q_w   = {q_w[WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial  = trial - {1'b0, dvs_q};
        q_w[0] = 1'b1;
      end
      r_w = trial[CoefBits-1:0];
    end
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = q_w;
      rem_d = r_w;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### design/half_wave_sine_shaper_top.sv
// Half-wave sine shaper. Each input transaction carries one signed Q1.23 sample;
// samples on the selected half-wave (positive, or negative when invert_polarity
// is set; zero never counts) are mapped through sin(x*pi/2)/(pi/2), evaluated as
// a 13-term Taylor series with GUARD_BITS extra fraction bits, and rounded back
// to the sample grid with leaky error feedback and saturation. Other samples
// pass through unchanged while the feedback accumulator decays. Two
// accumulators serve even and odd samples in turn. The block works on one
// sample at a time and holds in_ready_o low while busy. The shared multiplier
// takes 16-bit digits of its operand (3 at the default widths) and the series
// divider works in 4-bit steps (11 at the default widths). A shaped sample
// runs the series loop of multiply then divide; a passed-through sample runs
// only the leak multiply. A finished result waits in an output register, so
// the next sample is accepted while the previous result is still pending.
// invert_polarity may only be written while no sample is in flight.
module half_wave_sine_shaper_top import hws_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int GUARD_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   invert_polarity_i,
  // Sample input channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   block_end_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0] shaped_sample_o,
  output logic                   block_end_out_o
);

  // Fixed-point grid of the curve evaluation: W fraction bits.
  localparam int W    = SAMPLE_BITS - 1 + GUARD_BITS;
  // Every series value stays below 2^(W+2).
  localparam int VW   = W + 2;
  // The multiplier also carries the 33-bit accumulator difference.
  localparam int MW   = (VW > 33) ? VW : 33;
  localparam int MWP  = ((MW + MulDigit - 1) / MulDigit) * MulDigit;
  localparam int DIVW = ((VW + DivStep - 1) / DivStep) * DivStep;
  localparam int SUMW = VW + 1;
  localparam int FW   = ((SUMW > 32) ? SUMW : 32) + 2;
  localparam int RW   = FW - GUARD_BITS;
  localparam int EW   = GUARD_BITS + 2;

  localparam logic [63:0]            CurveSq = curve_square(W);
  localparam logic [MWP-1:0]         C2Op    = MWP'(CurveSq);
  localparam logic signed [SUMW-1:0] HalfY   = SUMW'(64'd1 << (GUARD_BITS - 1));
  localparam logic signed [EW-1:0]   HalfE   = EW'(64'd1 << (GUARD_BITS - 1));
  localparam logic signed [RW-1:0]   MaxOut  = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]   MinOut  = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  // Sequencer states.
  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSquare = 3'd1;
  localparam logic [2:0] StScale  = 3'd2;
  localparam logic [2:0] StTerm   = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StErr    = 3'd5;
  localparam logic [2:0] StLeak   = 3'd6;
  localparam logic [2:0] StFinal  = 3'd7;

  logic [2:0]              state_q, state_d;
  logic                    inv_q;
  logic                    phase_q, phase_d;
  logic                    sel_q, sel_d;
  logic                    shape_q, shape_d;
  logic [SAMPLE_BITS-1:0]  sample_q, sample_d;
  logic                    blk_q, blk_d;
  logic signed [31:0]      acc_even_q, acc_even_d;
  logic signed [31:0]      acc_odd_q, acc_odd_d;
  logic [VW-1:0]           u2_q, u2_d;
  logic signed [SUMW-1:0]  sum_q, sum_d;
  logic [TermIdxBits-1:0]  k_q, k_d;
  logic signed [SUMW-1:0]  y_q, y_d;
  logic                    neg_q, neg_d;
  logic [MWP-1:0]          op_a_q, op_a_d;
  logic [MWP-1:0]          op_b_q, op_b_d;
  logic                    mstart_q, mstart_d;
  logic                    dstart_q, dstart_d;
  logic [DIVW-1:0]         dvd_q, dvd_d;
  logic [CoefBits-1:0]     coef_q, coef_d;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]  out_sample_q, out_sample_d;
  logic                    out_blk_q, out_blk_d;

  logic                    mdone;
  logic [2*MWP-1:0]        mprod;
  logic                    ddone;
  logic [DIVW-1:0]         dquot;

  logic                    accept;
  logic                    in_neg;
  logic                    in_shape;
  logic [SAMPLE_BITS:0]    in_negx;
  logic [SAMPLE_BITS-1:0]  in_abs;
  logic [VW-1:0]           in_t;
  logic [VW-1:0]           mres;
  logic [VW-1:0]           qv;
  logic signed [31:0]      acc_cur;
  logic signed [SUMW-1:0]  y_e;
  logic signed [SUMW-1:0]  ev;
  logic signed [EW-1:0]    err_e;
  logic signed [32:0]      diff;
  logic [32:0]             mag;
  logic [63:0]             lp;
  logic signed [64:0]      lsp;
  logic signed [64:0]      lsr;
  logic signed [31:0]      acc_new;
  logic signed [FW-1:0]    fsum;
  logic signed [RW-1:0]    rnd;
  logic [SAMPLE_BITS-1:0]  sat_out;

  hws_mul #(
    .WIDTH (MWP)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .done_o  (mdone),
    .prod_o  (mprod)
  );

  hws_div #(
    .WIDTH (DIVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart_q),
    .dividend_i (dvd_q),
    .divisor_i  (coef_q),
    .done_o     (ddone),
    .quot_o     (dquot)
  );

  // The configuration register is always ready; the user must write it only when idle, the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Input decode: which half-wave, and |x| moved onto the W-bit grid.
  assign in_neg   = sample_i[SAMPLE_BITS-1];
  assign in_shape = inv_q ? in_neg : (!in_neg && (sample_i != '0));
  assign in_negx  = -{sample_i[SAMPLE_BITS-1], sample_i};
  assign in_abs   = in_neg ? in_negx[SAMPLE_BITS-1:0] : sample_i;
  assign in_t     = VW'({in_abs, {GUARD_BITS{1'b0}}});

  // (a*b) >> W for the series arithmetic; the result always fits VW bits.
  assign mres = mprod[W +: VW];
  assign qv   = dquot[VW-1:0];

  assign acc_cur = sel_q ? acc_even_q : acc_odd_q;

  // Rounding error of y on the output grid, in [-half, half).
  assign y_e   = inv_q ? -sum_q : sum_q;
  assign ev    = y_e + HalfY;
  assign err_e = $signed({2'b00, ev[GUARD_BITS-1:0]}) - HalfE;

  // The leak acc*OLD + err*NEW equals acc*2^32 + (err - acc)*NEW, so only the
  // difference goes through the multiplier, as a magnitude with its sign kept.
  assign diff = 33'(err_e) - 33'(acc_cur);
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  assign lp      = mprod[63:0];
  assign lsp     = neg_q ? -$signed({1'b0, lp}) : $signed({1'b0, lp});
  assign lsr     = lsp + 65'sd2147483648;
  assign acc_new = acc_cur + $signed(lsr[63:32]);

  // Final rounding of y plus the updated accumulator, then saturation.
  assign fsum = FW'(y_q) + FW'(acc_cur) + FW'(HalfY);
  assign rnd  = fsum[FW-1:GUARD_BITS];

  always_comb begin
    if (rnd > MaxOut) begin
      sat_out = MaxOut[SAMPLE_BITS-1:0];
    end else if (rnd < MinOut) begin
      sat_out = MinOut[SAMPLE_BITS-1:0];
    end else begin
      sat_out = rnd[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer. Each multiply or divide is launched by a one-cycle start pulse
  // from a register, and the state waits for the unit's done pulse.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q ^ accept;
    sel_d        = sel_q;
    shape_d      = shape_q;
    sample_d     = sample_q;
    blk_d        = blk_q;
    acc_even_d   = acc_even_q;
    acc_odd_d    = acc_odd_q;
    u2_d         = u2_q;
    sum_d        = sum_q;
    k_d          = k_q;
    y_d          = y_q;
    neg_d        = neg_q;
    op_a_d       = op_a_q;
    op_b_d       = op_b_q;
    mstart_d     = 1'b0;
    dstart_d     = 1'b0;
    dvd_d        = dvd_q;
    coef_d       = coef_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_blk_d    = out_blk_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          sample_d = sample_i;
          blk_d    = block_end_i;
          sel_d    = phase_q;
          shape_d  = in_shape;
          if (in_shape) begin
            // The running sum starts at t, the first series term.
            sum_d    = $signed(SUMW'(in_t));
            op_a_d   = MWP'(in_t);
            op_b_d   = MWP'(in_t);
            mstart_d = 1'b1;
            state_d  = StSquare;
          end else begin
            // Pass-through: y is zero, so the error is zero and the
            // accumulator only decays.
            sum_d   = '0;
            state_d = StErr;
          end
        end
      end
      StSquare: begin
        if (mdone) begin
          op_a_d   = MWP'(mres);
          op_b_d   = C2Op;
          mstart_d = 1'b1;
          state_d  = StScale;
        end
      end
      StScale: begin
        if (mdone) begin
          u2_d     = mres;
          op_a_d   = MWP'(sum_q[VW-1:0]);
          op_b_d   = MWP'(mres);
          k_d      = TermIdxBits'(1);
          mstart_d = 1'b1;
          state_d  = StTerm;
        end
      end
      StTerm: begin
        if (mdone) begin
          dvd_d    = DIVW'(mres);
          coef_d   = series_coef(k_q);
          dstart_d = 1'b1;
          state_d  = StDiv;
        end
      end
      StDiv: begin
        if (ddone) begin
          // Odd terms subtract, even terms add.
          if (k_q[0]) begin
            sum_d = sum_q - $signed(SUMW'(qv));
          end else begin
            sum_d = sum_q + $signed(SUMW'(qv));
          end
          if (k_q == TermIdxBits'(SeriesTerms)) begin
            state_d = StErr;
          end else begin
            k_d      = k_q + 1'b1;
            op_a_d   = MWP'(qv);
            op_b_d   = MWP'(u2_q);
            mstart_d = 1'b1;
            state_d  = StTerm;
          end
        end
      end
      StErr: begin
        y_d      = y_e;
        neg_d    = diff[32];
        op_a_d   = MWP'(LeakNew);
        op_b_d   = MWP'(mag);
        mstart_d = 1'b1;
        state_d  = StLeak;
      end
      StLeak: begin
        if (mdone) begin
          if (sel_q) begin
            acc_even_d = acc_new;
          end else begin
            acc_odd_d = acc_new;
          end
          state_d = StFinal;
        end
      end
      StFinal: begin
        // Hand the result over once the output register is free or being
        // emptied in this cycle.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = shape_q ? sat_out : sample_q;
          out_blk_d    = blk_q;
          state_d      = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      inv_q       <= 1'b0;
      phase_q     <= 1'b1;
      acc_even_q  <= '0;
      acc_odd_q   <= '0;
      mstart_q    <= 1'b0;
      dstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      acc_even_q  <= acc_even_d;
      acc_odd_q   <= acc_odd_d;
      mstart_q    <= mstart_d;
      dstart_q    <= dstart_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        inv_q <= invert_polarity_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    shape_q      <= shape_d;
    sample_q     <= sample_d;
    blk_q        <= blk_d;
    u2_q         <= u2_d;
    sum_q        <= sum_d;
    k_q          <= k_d;
    y_q          <= y_d;
    neg_q        <= neg_d;
    op_a_q       <= op_a_d;
    op_b_q       <= op_b_d;
    dvd_q        <= dvd_d;
    coef_q       <= coef_d;
    out_sample_q <= out_sample_d;
    out_blk_q    <= out_blk_d;
  end

  assign out_valid_o     = out_valid_q;
  assign shaped_sample_o = out_sample_q;
  assign block_end_out_o = out_blk_q;

endmodule

### design/hws_checker.sv
module hws_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] shaped_sample_o,
  input logic                   block_end_out_o
);

  // An accepted sample keeps the block busy, with in_ready_o held low after the accept.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("input accepted again too soon after a transaction");

  // A stalled result holds its value.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(shaped_sample_o) && $stable(block_end_out_o)))
    else $error("pending result changed or dropped");

  // A new result appears exactly when the block returns from work to idle.
  a_out_with_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (in_ready_o && !$past(in_ready_o)))
    else $error("result appeared without the block finishing a transaction");

endmodule

bind half_wave_sine_shaper_top hws_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_hws_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .shaped_sample_o (shaped_sample_o),
  .block_end_out_o (block_end_out_o)
);

### tb/half_wave_sine_shaper_top_test.sv
module half_wave_sine_shaper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths of the block as instantiated here (its default parameters).
  localparam int SampleW = 24;
  localparam int GuardW  = 16;
  // Fraction bits of the internal curve arithmetic.
  localparam int FracW   = SampleW - 1 + GuardW;
  localparam int SeriesLen = 12;

  // Leak weights in Q0.32: old share and new share sum to 2^32.
  localparam longint OldWeight = 64'sd2654435769;
  localparam longint NewWeight = 64'sd1640531527;

  localparam longint SampleMax = (64'sd1 <<< (SampleW - 1)) - 1;
  localparam longint SampleMin = -(64'sd1 <<< (SampleW - 1));

  // Wait after the final drain; a receiver stall can hold back a result.
  localparam int DrainCycles = 400;
  localparam int WatchdogLimit = 5000;
  localparam int RandomPerPhase = 167;

  typedef struct packed {
    logic [SampleW-1:0] shaped;
    logic               block_end;
  } shaped_item_t;

  // One row of the directed table. Where known is set, the shaped value is
  // obvious from the stimulus (a passed-through sample) and is typed in.
  typedef struct packed {
    logic               pol;
    logic [SampleW-1:0] sample;
    logic               block_end;
    logic               known;
    logic [SampleW-1:0] shaped;
  } stim_row_t;

  localparam int DirCount = 20;
  localparam stim_row_t DirRows [DirCount] = '{
    // Normal mode: zero and the negative half pass straight through.
    '{1'b0, 24'h000000, 1'b0, 1'b1, 24'h000000},
    '{1'b0, 24'h800000, 1'b1, 1'b1, 24'h800000},
    '{1'b0, 24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF},
    '{1'b0, 24'h000001, 1'b0, 1'b0, 24'h000000},
    '{1'b0, 24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
    '{1'b0, 24'h400000, 1'b0, 1'b0, 24'h000000},
    '{1'b0, 24'h123456, 1'b1, 1'b0, 24'h000000},
    '{1'b0, 24'h800001, 1'b0, 1'b1, 24'h800001},
    '{1'b0, 24'h7FFFFF, 1'b1, 1'b0, 24'h000000},
    // Inverse mode: the positive half and zero pass, negatives are shaped,
    // full-scale negative included.
    '{1'b1, 24'h000000, 1'b0, 1'b1, 24'h000000},
    '{1'b1, 24'h7FFFFF, 1'b0, 1'b1, 24'h7FFFFF},
    '{1'b1, 24'h000001, 1'b1, 1'b1, 24'h000001},
    '{1'b1, 24'h800000, 1'b0, 1'b0, 24'h000000},
    '{1'b1, 24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
    '{1'b1, 24'hC00000, 1'b0, 1'b0, 24'h000000},
    '{1'b1, 24'h800001, 1'b1, 1'b0, 24'h000000},
    '{1'b1, 24'h800000, 1'b0, 1'b0, 24'h000000},
    // Back to normal mode with the accumulators carrying history.
    '{1'b0, 24'h555555, 1'b0, 1'b0, 24'h000000},
    '{1'b0, 24'hAAAAAA, 1'b1, 1'b1, 24'hAAAAAA},
    '{1'b0, 24'h000001, 1'b0, 1'b0, 24'h000000}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               invert_polarity_i = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i = '0;
  logic               block_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [SampleW-1:0] shaped_sample_o;
  logic               block_end_out_o;

  half_wave_sine_shaper_top #(
    .SAMPLE_BITS(SampleW),
    .GUARD_BITS (GuardW)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .invert_polarity_i(invert_polarity_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .block_end_i      (block_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .shaped_sample_o  (shaped_sample_o),
    .block_end_out_o  (block_end_out_o)
  );

  always #1 clk_i = ~clk_i;

  // Shadow state of the block: the polarity register, the two error
  // accumulators and the flag that picks the even one.
  logic               invert_q = 1'b0;
  logic signed [31:0] feedback_acc [2] = '{32'sd0, 32'sd0};
  logic               even_turn = 1'b1;

  // Expected results in order of the sample transactions that caused them.
  shaped_item_t shaped_q [$];

  int fail_cnt    = 0;
  int shaped_cnt  = 0;
  int passed_cnt  = 0;
  int result_cnt  = 0;
  int pol_writes  = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left  = 0;
  int quiet_cycles = 0;

  // (a * b) scaled back down by the fraction width, with the full product kept.
  function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> FracW);
  endfunction

  // sin(t*c)/c with c just above pi/2, as the alternating Taylor series.
  // Each term divides the previous one by (2k)(2k+1) after scaling by u^2.
  function automatic longint sine_series(input logic [63:0] t);
    logic [127:0] cw_wide;
    logic [63:0]  cw;
    logic [63:0]  u2;
    logic [63:0]  term;
    longint       mag;
    cw_wide = (128'd157079634 << FracW) / 128'd100000000;
    cw      = cw_wide[63:0];
    u2      = frac_mul(frac_mul(t, t), frac_mul(cw, cw));
    term    = t;
    mag     = longint'(t);
    for (int k = 1; k <= SeriesLen; k++) begin
      term = frac_mul(term, u2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        mag = mag - longint'(term);
      end else begin
        mag = mag + longint'(term);
      end
    end
    return mag;
  endfunction

  // Round half up onto the output grid (floor of value plus half an LSB).
  function automatic longint grid_round(input longint v);
    return (v + (64'sd1 <<< (GuardW - 1))) >>> GuardW;
  endfunction

  // One leak step: 0.618 of the old error plus 0.382 of the new, rounded,
  // and kept to 32 bits.
  function automatic logic signed [31:0] leak_step(input logic signed [31:0] acc,
                                                   input longint err);
    longint v;
    longint r;
    v = longint'(acc) * OldWeight + err * NewWeight;
    r = (v + (64'sd1 <<< 31)) >>> 32;
    return r[31:0];
  endfunction

  // Advances the shadow state by one sample and returns the result it causes.
  function automatic shaped_item_t shape_sample(input logic [SampleW-1:0] s,
                                                input logic be);
    shaped_item_t item;
    longint       x;
    longint       y;
    longint       err;
    longint       v;
    int           sel;
    logic         on_curve;
    x        = longint'($signed(s));
    sel      = even_turn ? 0 : 1;
    on_curve = invert_q ? (x < 0) : (x > 0);
    item.block_end = be;
    if (on_curve) begin
      y = sine_series(64'(x < 0 ? -x : x) << GuardW);
      if (invert_q) begin
        y = -y;
      end
      err = y - grid_round(y) * (64'sd1 <<< GuardW);
      feedback_acc[sel] = leak_step(feedback_acc[sel], err);
      v = grid_round(y + longint'(feedback_acc[sel]));
      if (v > SampleMax) begin
        v = SampleMax;
      end
      if (v < SampleMin) begin
        v = SampleMin;
      end
      item.shaped = v[SampleW-1:0];
      shaped_cnt++;
    end else begin
      // Off the shaped half-wave the sample passes and the error only decays.
      feedback_acc[sel] = leak_step(feedback_acc[sel], 0);
      item.shaped = s;
      passed_cnt++;
    end
    even_turn = ~even_turn;
    return item;
  endfunction

  // Presents one sample and waits for its transaction. The expectation comes
  // from the shadow state, or from the table when a row types it in.
  task automatic send_sample(input logic [SampleW-1:0] s, input logic be,
                             input logic known, input logic [SampleW-1:0] known_shaped);
    shaped_item_t item;
    in_valid_i  <= 1'b1;
    sample_i    <= s;
    block_end_i <= be;
    do @(posedge clk_i); while (!in_ready_o);
    item = shape_sample(s, be);
    if (known) begin
      item.shaped = known_shaped;
    end
    shaped_q.push_back(item);
  endtask

  // Stops sending and waits until every expected result has come back, so the
  // block holds no sample.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (shaped_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Writes the polarity register; only called while the block is idle.
  task automatic write_polarity(input logic pol);
    cfg_valid_i       <= 1'b1;
    invert_polarity_i <= pol;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    invert_q = pol;
    pol_writes++;
  endtask

  function automatic logic [SampleW-1:0] random_sample();
    int pick;
    logic [SampleW-1:0] s;
    pick = $urandom_range(99);
    if (pick < 45) begin
      s = SampleW'($urandom);
    end else if (pick < 60) begin
      // Small magnitudes of either sign, where the curve is nearly linear.
      s = SampleW'($urandom_range(255));
      if ($urandom_range(1) == 1) begin
        s = -s;
      end
    end else if (pick < 75) begin
      // Near full scale, where the curve flattens out.
      s = $urandom_range(1) ? 24'h7FFFFF - SampleW'($urandom_range(4095))
                            : 24'h800000 + SampleW'($urandom_range(4095));
    end else if (pick < 83) begin
      s = '0;
    end else if (pick < 87) begin
      s = 24'h7FFFFF;
    end else if (pick < 91) begin
      s = 24'h800000;
    end else if (pick < 95) begin
      s = 24'h000001;
    end else begin
      s = 24'hFFFFFF;
    end
    return s;
  endfunction

  // Result side: each transaction is checked against the oldest expectation,
  // then the ready line is redrawn. Now and then the receiver holds off for a
  // long stretch so that a finished result sits waiting while the block works.
  always @(posedge clk_i) begin : result_check
    shaped_item_t want;
    if (out_valid_o && out_ready_i) begin
      result_cnt++;
      if (shaped_q.size() == 0) begin
        $error("result transaction with nothing expected: shaped_sample=%h block_end_out=%b",
               shaped_sample_o, block_end_out_o);
        fail_cnt++;
      end else begin
        want = shaped_q.pop_front();
        if (shaped_sample_o !== want.shaped) begin
          $error("shaped_sample: expected %h, actual %h", want.shaped, shaped_sample_o);
          fail_cnt++;
        end
        if (block_end_out_o !== want.block_end) begin
          $error("block_end_out: expected %b, actual %b", want.block_end, block_end_out_o);
          fail_cnt++;
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      out_ready_i <= 1'b0;
      if ($urandom_range(1023) == 0) begin
        stall_left = $urandom_range(300, 1);
      end
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
               WatchdogLimit, shaped_q.size());
      $display("half_wave_sine_shaper_top_test: FAIL");
      $finish;
    end
  end

  initial begin
    // Idle percentages of sender and receiver for each random phase, and the
    // polarity each phase starts with.
    int tx_pct [3];
    int rx_pct [3];
    logic start_pol [3];
    tx_pct = '{20, 52, 0};
    rx_pct = '{52, 20, 0};
    start_pol = '{1'b1, 1'b0, 1'b1};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register is set explicitly even though it resets to normal mode.
    write_polarity(1'b0);

    // Directed table; a change of polarity between rows waits for idle first.
    for (int i = 0; i < DirCount; i++) begin
      if (DirRows[i].pol != invert_q) begin
        drain_results();
        write_polarity(DirRows[i].pol);
      end
      send_sample(DirRows[i].sample, DirRows[i].block_end,
                  DirRows[i].known, DirRows[i].shaped);
    end

    // Random phases with different idling on the two sides. Halfway through
    // each phase the sender holds off until the block has emptied; in the last
    // phase the polarity flips there too.
    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      tx_idle_pct = tx_pct[ph];
      rx_idle_pct = rx_pct[ph];
      write_polarity(start_pol[ph]);
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (n == RandomPerPhase / 2) begin
          drain_results();
          if (ph == 2) begin
            write_polarity(1'b0);
          end
        end
        send_sample(random_sample(), $urandom_range(7) == 0, 1'b0, '0);
        if ($urandom_range(99) < tx_idle_pct) begin
          in_valid_i <= 1'b0;
          if ($urandom_range(15) == 0) begin
            repeat ($urandom_range(300, 1)) @(posedge clk_i);
          end else begin
            do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
          end
        end
      end
    end

    // Wait for every outstanding result, then long enough for a stray one.
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (shaped_q.size() != 0) begin
      $error("%0d expected results never arrived", shaped_q.size());
      fail_cnt++;
    end

    $display("Sent %0d samples (%0d on the curve, %0d passed through), checked %0d results,",
             shaped_cnt + passed_cnt, shaped_cnt, passed_cnt, result_cnt);
    $display("with %0d polarity writes covering normal and inverse mode.", pol_writes);
    if (fail_cnt == 0) begin
      $display("half_wave_sine_shaper_top_test: PASS");
    end else begin
      $display("half_wave_sine_shaper_top_test: FAIL");
    end
    $finish;
  end

endmodule
